### hw/rtl/cpvl_pkg.sv
// ----------------------------------------------------------------------------
// cpvl_pkg
// Shared types, register map and constants for the Cartesian PID velocity loop.
// ----------------------------------------------------------------------------
package cpvl_pkg;

  localparam int AXES_DEF = 3;   // axes processed by default
  localparam int NAX      = 3;   // axes carried in the request and result
  localparam int CFG_AW   = 5;   // APB byte address width, 8 registers at 4*i

  // register reset values
  localparam logic [31:0] PROP_GAIN_RST   = 32'd16384;
  localparam logic [31:0] DERIV_GAIN_RST  = 32'd18350080;
  localparam logic [31:0] INTEG_GAIN_RST  = 32'd245426;
  localparam logic [31:0] LEAK_RST        = 32'h8000_0000;
  localparam logic [30:0] INTEG_LIMIT_RST = 31'd1677722;
  localparam logic [30:0] UPDATE_TOL_RST  = 31'd83886;
  localparam logic [30:0] DEADBAND_RST    = 31'd83886;
  localparam logic [30:0] VEL_LIMIT_RST   = 31'd1342177;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_DERIV_GAIN  = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_LEAK        = 3'd3,
    REG_INTEG_LIMIT = 3'd4,
    REG_UPDATE_TOL  = 3'd5,
    REG_DEADBAND    = 3'd6,
    REG_VEL_LIMIT   = 3'd7
  } reg_addr_t;

  typedef struct packed {
    logic [31:0] prop_gain;
    logic [31:0] deriv_gain_over_period;
    logic [31:0] integ_gain_times_period;
    logic [31:0] leak_factor;
    logic [30:0] integral_limit;
    logic [30:0] update_tolerance;
    logic [30:0] error_deadband;
    logic [30:0] velocity_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] measured_x;
    logic signed [31:0] measured_y;
    logic signed [31:0] measured_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic               reference_updated;
    logic               in_deadband;
  } out_item_t;

  // multiplier operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TOL,   // tolerance squared
    OP_DB,    // deadband squared
    OP_SQD,   // (target - reference)^2
    OP_SQE,   // (reference - measured)^2
    OP_IG,    // integral gain * error
    OP_PT,    // proportional gain * error
    OP_LK,    // leak * integrator
    OP_DV     // derivative gain * position delta
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOL,
    ST_DB,
    ST_SQD,
    ST_SQD_W,
    ST_SQE,
    ST_SQE_W,
    ST_CHK,
    ST_IG,
    ST_PT,
    ST_LK,
    ST_DV,
    ST_FIN_W,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic    start;   // latch request, clear per-tick flags
    mul_op_t op;
    logic    load;    // load result register, store previous position
  } dp_cmd_t;

  typedef struct packed {
    logic dead;
  } dp_stat_t;

endpackage

### hw/rtl/cpvl_regs.sv
// ----------------------------------------------------------------------------
// cpvl_regs
// APB configuration registers: gains, leak, limits and tolerances.
// ----------------------------------------------------------------------------
module cpvl_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpvl_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output cpvl_pkg::cfg_t                cfg
);
  import cpvl_pkg::*;

  cfg_t      cfg_r;
  cfg_t      cfg_nxt;
  logic      wr_en;
  reg_addr_t addr;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign addr   = reg_addr_t'(paddr[CFG_AW-1:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (addr)
        REG_PROP_GAIN:   cfg_nxt.prop_gain               = pwdata;
        REG_DERIV_GAIN:  cfg_nxt.deriv_gain_over_period  = pwdata;
        REG_INTEG_GAIN:  cfg_nxt.integ_gain_times_period = pwdata;
        REG_LEAK:        cfg_nxt.leak_factor             = pwdata;
        REG_INTEG_LIMIT: cfg_nxt.integral_limit          = pwdata[30:0];
        REG_UPDATE_TOL:  cfg_nxt.update_tolerance        = pwdata[30:0];
        REG_DEADBAND:    cfg_nxt.error_deadband          = pwdata[30:0];
        REG_VEL_LIMIT:   cfg_nxt.velocity_limit          = pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (addr)
      REG_PROP_GAIN:   prdata = cfg_r.prop_gain;
      REG_DERIV_GAIN:  prdata = cfg_r.deriv_gain_over_period;
      REG_INTEG_GAIN:  prdata = cfg_r.integ_gain_times_period;
      REG_LEAK:        prdata = cfg_r.leak_factor;
      REG_INTEG_LIMIT: prdata = {1'b0, cfg_r.integral_limit};
      REG_UPDATE_TOL:  prdata = {1'b0, cfg_r.update_tolerance};
      REG_DEADBAND:    prdata = {1'b0, cfg_r.error_deadband};
      REG_VEL_LIMIT:   prdata = {1'b0, cfg_r.velocity_limit};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain               <= PROP_GAIN_RST;
      cfg_r.deriv_gain_over_period  <= DERIV_GAIN_RST;
      cfg_r.integ_gain_times_period <= INTEG_GAIN_RST;
      cfg_r.leak_factor             <= LEAK_RST;
      cfg_r.integral_limit          <= INTEG_LIMIT_RST;
      cfg_r.update_tolerance        <= UPDATE_TOL_RST;
      cfg_r.error_deadband          <= DEADBAND_RST;
      cfg_r.velocity_limit          <= VEL_LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hw/rtl/cpvl_ctrl.sv
// ----------------------------------------------------------------------------
// cpvl_ctrl
// Sequencer: walks the shared multiplier through one control tick and owns
// the request and result handshakes.
// ----------------------------------------------------------------------------
module cpvl_ctrl #(
  parameter  int AXES = cpvl_pkg::AXES_DEF,
  localparam int AXW  = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  cpvl_pkg::dp_stat_t stat,
  output cpvl_pkg::dp_cmd_t  cmd,
  output logic [AXW-1:0]     cmd_axis
);
  import cpvl_pkg::*;

  localparam logic [AXW-1:0] AX_LAST = AXW'(AXES - 1);

  ctrl_state_t    state_r, state_nxt;
  logic [AXW-1:0] ax_r, ax_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           ax_last;

  assign ax_last  = (ax_r == AX_LAST);
  assign cmd_axis = ax_r;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_TOL;
      ST_TOL:   state_nxt = ST_DB;
      ST_DB: begin
        state_nxt = ST_SQD;
        ax_nxt    = '0;
      end
      ST_SQD: begin
        if (ax_last) begin
          state_nxt = ST_SQD_W;
          ax_nxt    = '0;
        end else begin
          ax_nxt = ax_r + 1'b1;
        end
      end
      ST_SQD_W: state_nxt = ST_SQE;
      ST_SQE: begin
        if (ax_last) begin
          state_nxt = ST_SQE_W;
          ax_nxt    = '0;
        end else begin
          ax_nxt = ax_r + 1'b1;
        end
      end
      ST_SQE_W: state_nxt = ST_CHK;
      ST_CHK:   state_nxt = stat.dead ? ST_OUT : ST_IG;
      ST_IG:    state_nxt = ST_PT;
      ST_PT:    state_nxt = ST_LK;
      ST_LK:    state_nxt = ST_DV;
      ST_DV: begin
        if (ax_last) begin
          state_nxt = ST_FIN_W;
          ax_nxt    = '0;
        end else begin
          state_nxt = ST_IG;
          ax_nxt    = ax_r + 1'b1;
        end
      end
      ST_FIN_W: state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_TOL:  cmd.op = OP_TOL;
      ST_DB:   cmd.op = OP_DB;
      ST_SQD:  cmd.op = OP_SQD;
      ST_SQE:  cmd.op = OP_SQE;
      ST_IG:   cmd.op = OP_IG;
      ST_PT:   cmd.op = OP_PT;
      ST_LK:   cmd.op = OP_LK;
      ST_DV:   cmd.op = OP_DV;
      ST_OUT:  cmd.load = !out_valid_r || out_ready;
      default: cmd.op = OP_NONE;
    endcase
  end

  assign out_valid_nxt = cmd.load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/cpvl_dp.sv
// ----------------------------------------------------------------------------
// cpvl_dp
// Datapath: one shared 33x32 multiplier with a registered product, the
// rounding / accumulate / clamp logic that consumes it, and the loop state.
// ----------------------------------------------------------------------------
module cpvl_dp #(
  parameter  int AXES = cpvl_pkg::AXES_DEF,
  localparam int AXW  = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cpvl_pkg::cfg_t      cfg,
  input  cpvl_pkg::in_item_t  in_data,
  input  cpvl_pkg::dp_cmd_t   cmd,
  input  logic [AXW-1:0]      cmd_axis,
  output cpvl_pkg::dp_stat_t  stat,
  output cpvl_pkg::out_item_t out_data
);
  import cpvl_pkg::*;

  localparam logic [AXW-1:0] AX_LAST = AXW'(AXES - 1);

  // loop state
  logic signed [31:0] ref_r  [AXES];
  logic signed [31:0] acc_r  [AXES];
  logic signed [31:0] prev_r [AXES];
  logic               prev_valid_r;
  logic               upd_r;
  logic               dead_r;
  mul_op_t            pop_r;

  // per-tick working registers
  in_item_t           in_r;
  logic signed [31:0] tgt_a  [AXES];
  logic signed [31:0] meas_a [AXES];
  logic signed [32:0] err_r  [AXES];
  logic signed [32:0] dif_r  [AXES];
  logic signed [31:0] vel_r  [AXES];
  logic signed [31:0] vel_p  [NAX];
  logic [61:0]        tol2_r;
  logic [61:0]        db2_r;
  logic [63:0]        sq_r;
  logic [64:0]        prod_r;
  logic               pneg_r;
  logic [AXW-1:0]     pax_r;
  logic signed [33:0] s_r;
  logic signed [50:0] p_r;
  logic signed [31:0] i_r;
  out_item_t          out_r;

  // issue side
  logic signed [32:0] dst_now, err_now, dif_now;
  logic signed [33:0] sop;
  logic [33:0]        mag;
  logic [31:0]        mul_b;
  logic [64:0]        prod_nxt;

  // consume side
  logic [65:0]        pr_e, rs32, rs31, rs16;
  logic [33:0]        r32;
  logic [34:0]        r31;
  logic [49:0]        r16;
  logic signed [34:0] ig_v, s_sum;
  logic signed [35:0] lk_v, s_lk, ilim;
  logic signed [31:0] s_cl;
  logic signed [50:0] pd_v, d_val;
  logic signed [52:0] v_sum, vlim;
  logic signed [31:0] v_cl;
  logic [64:0]        sq_sum;
  logic [63:0]        sq_sat;
  logic               pax_last;
  logic               relatch;
  logic               dead_hit;
  out_item_t          out_nxt;

  genvar gi;
  generate
    for (gi = 0; gi < AXES; gi++) begin : g_ax
      assign tgt_a[gi]  = (gi == 0) ? in_r.target_x :
                          (gi == 1) ? in_r.target_y : in_r.target_z;
      assign meas_a[gi] = (gi == 0) ? in_r.measured_x :
                          (gi == 1) ? in_r.measured_y : in_r.measured_z;
    end
    for (gi = 0; gi < NAX; gi++) begin : g_vel
      if (gi < AXES) begin : g_used
        assign vel_p[gi] = vel_r[gi];
      end else begin : g_unused
        assign vel_p[gi] = '0;
      end
    end
  endgenerate

  // ---------------- multiplier issue ----------------
  always_comb begin
    dst_now = 33'(tgt_a[cmd_axis]) - 33'(ref_r[cmd_axis]);
    err_now = 33'(ref_r[cmd_axis]) - 33'(meas_a[cmd_axis]);
    dif_now = 33'(meas_a[cmd_axis]) - 33'(prev_r[cmd_axis]);
    case (cmd.op)
      OP_TOL:  sop = 34'(cfg.update_tolerance);
      OP_DB:   sop = 34'(cfg.error_deadband);
      OP_SQD:  sop = 34'(dst_now);
      OP_SQE:  sop = 34'(err_now);
      OP_IG:   sop = 34'(err_r[cmd_axis]);
      OP_PT:   sop = 34'(err_r[cmd_axis]);
      OP_LK:   sop = s_r;
      OP_DV:   sop = 34'(dif_r[cmd_axis]);
      default: sop = '0;
    endcase
    mag = sop[33] ? -sop : sop;
    case (cmd.op)
      OP_TOL:  mul_b = 32'(cfg.update_tolerance);
      OP_DB:   mul_b = 32'(cfg.error_deadband);
      OP_SQD:  mul_b = mag[31:0];
      OP_SQE:  mul_b = mag[31:0];
      OP_IG:   mul_b = cfg.integ_gain_times_period;
      OP_PT:   mul_b = cfg.prop_gain;
      OP_LK:   mul_b = {1'b0, cfg.leak_factor[30:0]};
      OP_DV:   mul_b = cfg.deriv_gain_over_period;
      default: mul_b = '0;
    endcase
    prod_nxt = 65'(mag[32:0]) * 65'(mul_b);
  end

  // ---------------- product consume ----------------
  always_comb begin
    pr_e = {1'b0, prod_r};
    rs32 = pr_e + (66'd1 << 31);
    rs31 = pr_e + (66'd1 << 30);
    rs16 = pr_e + (66'd1 << 15);
    r32  = rs32[65:32];
    r31  = rs31[65:31];
    r16  = rs16[65:16];

    // integrator input
    ig_v  = pneg_r ? -$signed({1'b0, r32}) : $signed({1'b0, r32});
    s_sum = 35'(acc_r[pax_r]) + ig_v;

    // leak, skipped at or above one, then clamp
    lk_v = pneg_r ? -$signed({1'b0, r31}) : $signed({1'b0, r31});
    s_lk = cfg.leak_factor[31] ? 36'(s_r) : lk_v;
    ilim = $signed({5'b0, cfg.integral_limit});
    if (s_lk > ilim)       s_cl = ilim[31:0];
    else if (s_lk < -ilim) s_cl = 32'(-ilim);
    else                   s_cl = s_lk[31:0];

    // P and D share the Q16.16 rounding
    pd_v  = pneg_r ? -$signed({1'b0, r16}) : $signed({1'b0, r16});
    d_val = prev_valid_r ? pd_v : '0;
    v_sum = 53'(p_r) + 53'(i_r) - 53'(d_val);
    vlim  = $signed({22'b0, cfg.velocity_limit});
    if (v_sum > vlim)       v_cl = vlim[31:0];
    else if (v_sum < -vlim) v_cl = 32'(-vlim);
    else                    v_cl = v_sum[31:0];

    // saturating sum of squares, restarted on axis 0
    sq_sum   = 65'((pax_r == '0) ? 64'd0 : sq_r) + 65'(prod_r[63:0]);
    sq_sat   = sq_sum[64] ? '1 : sq_sum[63:0];
    pax_last = (pax_r == AX_LAST);
    relatch  = (pop_r == OP_SQD) && pax_last && (sq_sat > 64'(tol2_r));
    dead_hit = (pop_r == OP_SQE) && pax_last && (sq_sat < 64'(db2_r));

    out_nxt.velocity_x        = vel_p[0];
    out_nxt.velocity_y        = vel_p[1];
    out_nxt.velocity_z        = vel_p[2];
    out_nxt.reference_updated = upd_r;
    out_nxt.in_deadband       = dead_r;
  end

  assign stat.dead = dead_r;
  assign out_data  = out_r;

  // loop state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r        <= OP_NONE;
      upd_r        <= 1'b0;
      dead_r       <= 1'b0;
      prev_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        ref_r[i]  <= '0;
        acc_r[i]  <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      pop_r <= cmd.op;
      if (cmd.start) begin
        upd_r  <= 1'b0;
        dead_r <= 1'b0;
      end
      if (relatch) begin
        upd_r <= 1'b1;
        for (int i = 0; i < AXES; i++) begin
          ref_r[i] <= tgt_a[i];
          acc_r[i] <= '0;
        end
      end
      if (dead_hit) begin
        dead_r <= 1'b1;
        for (int i = 0; i < AXES; i++) acc_r[i] <= '0;
      end
      if (pop_r == OP_LK) acc_r[pax_r] <= s_cl;
      if (cmd.load) begin
        prev_valid_r <= 1'b1;
        for (int i = 0; i < AXES; i++) prev_r[i] <= meas_a[i];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.start) in_r <= in_data;
    prod_r <= prod_nxt;
    pneg_r <= sop[33];
    pax_r  <= cmd_axis;
    if (pop_r == OP_TOL) tol2_r <= prod_r[61:0];
    if (pop_r == OP_DB)  db2_r  <= prod_r[61:0];
    if (pop_r == OP_SQD || pop_r == OP_SQE) sq_r <= sq_sat;
    if (cmd.op == OP_SQE) begin
      err_r[cmd_axis] <= err_now;
      dif_r[cmd_axis] <= dif_now;
    end
    if (pop_r == OP_IG) s_r <= s_sum[33:0];
    if (pop_r == OP_PT) p_r <= pd_v;
    if (pop_r == OP_LK) i_r <= (cfg.integ_gain_times_period != '0) ? s_cl : '0;
    if (cmd.start) begin
      for (int i = 0; i < AXES; i++) vel_r[i] <= '0;
    end else if (pop_r == OP_DV) begin
      vel_r[pax_r] <= v_cl;
    end
    if (cmd.load) out_r <= out_nxt;
  end

endmodule

### hw/rtl/cartesian_pid_velocity_loop.sv
// ----------------------------------------------------------------------------
// cartesian_pid_velocity_loop
// One request per control tick carries target and measured position (Q8.24 m)
// for three axes; the result carries the clamped PID velocity (Q8.24 m/s) and
// two flags. Every product goes through a single shared 33x32 multiplier with
// a registered output, issued one per cycle except in the wait and check
// states; a tick whose error falls inside the deadband skips the PID steps
// and goes straight to the result. The next request is taken once the
// result sits in the output register, even if it has not been taken yet.
// Registers are on an APB port at byte address 4*i: prop_gain,
// deriv_gain_over_period, integ_gain_times_period, leak_factor,
// integral_limit, update_tolerance, error_deadband, velocity_limit; write
// them only while no tick is in flight. Reset clears all loop state at once.
// ----------------------------------------------------------------------------
module cartesian_pid_velocity_loop #(
  parameter int AXES = cpvl_pkg::AXES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cpvl_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cpvl_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cpvl_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import cpvl_pkg::*;

  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

  cfg_t           cfg;
  dp_cmd_t        cmd;
  dp_stat_t       stat;
  logic [AXW-1:0] cmd_axis;

  cpvl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  cpvl_ctrl #(.AXES(AXES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .cmd_axis  (cmd_axis)
  );

  cpvl_dp #(.AXES(AXES)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_data  (in_data),
    .cmd      (cmd),
    .cmd_axis (cmd_axis),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
